// File: rtl/bfoa_pkg.sv
// Package for the best-fit offset allocator: command, status and controller types.
// No dependencies; used by every module under rtl.
package bfoa_pkg;
   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_OVERFLOW = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_OVERFREE = 2'd3;

   localparam logic [3:0] ALIGN_LOG2_RESET = 4'd8;
   localparam logic [3:0] ALIGN_LOG2_MAX   = 4'd12;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // capture request, align size
      logic check;    // run overflow checks
      logic scan;     // examine one table entry
      logic apply;    // update table and counters
      logic clear;    // clear table, counters, status and offset
      logic respond;  // drive the response strobe
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_last;  // entry being scanned is the last one
      logic early_done; // request finishes without a scan
   } sts_type;
endpackage

// File: rtl/bfoa_ctrl.sv
// Controller state machine of the best-fit offset allocator.
// Depends on bfoa_pkg.
module bfoa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output bfoa_pkg::ctl_type ctl,
   input  bfoa_pkg::sts_type sts
);
   import bfoa_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_APPLY = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            ctl.check = 1'b1;
            state_in  = sts.early_done ? S_RESP : S_SCAN;
         end
         S_SCAN: begin
            ctl.scan = 1'b1;
            if (sts.scan_last) state_in = S_APPLY;
         end
         S_APPLY: begin
            ctl.apply = 1'b1;
            state_in  = S_RESP;
         end
         S_RESP: begin
            ctl.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end
endmodule

// File: rtl/bfoa_datapath.sv
// Datapath of the best-fit offset allocator: free table, scan logic and counters.
// Depends on bfoa_pkg.
module bfoa_datapath #(
   parameter int FREE_ENTRIES = 64,
   parameter int ADDR_BITS    = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bfoa_pkg::ctl_type     ctl,
   output bfoa_pkg::sts_type     sts,
   input  logic [3:0]            align_log2,
   input  logic [1:0]            req_cmd,
   input  logic [31:0]           req_size,
   input  logic [31:0]           req_addr,
   output logic                  rsp_valid,
   output logic [31:0]           rsp_offset,
   output logic [31:0]           rsp_high_mark,
   output logic [31:0]           rsp_bytes_in_use,
   output logic [1:0]            rsp_status
);
   import bfoa_pkg::*;

   localparam int IW = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
   localparam int AW = ADDR_BITS;
   localparam int XW = (AW > 32) ? AW + 1 : 33;
   localparam logic [IW-1:0] LAST_IDX = IW'(FREE_ENTRIES - 1);

   logic [FREE_ENTRIES-1:0] valid_ff, valid_in;
   logic [AW-1:0] start_mem [FREE_ENTRIES];
   logic [AW-1:0] len_mem   [FREE_ENTRIES];

   logic [AW-1:0] peak_ff, used_ff;
   logic [1:0]    cmd_ff;
   logic [AW-1:0] need_ff, addr_ff, tail_ff;
   logic          ovf_ff;
   logic [1:0]    status_ff, status_in;
   logic [AW-1:0] offset_ff, offset_in;
   logic [IW-1:0] idx_ff;

   // scan results
   logic          best_hit_ff, prev_hit_ff, next_hit_ff, empty_hit_ff, endp_hit_ff;
   logic [IW-1:0] best_ff, prev_ff, next_ff, empty_ff, endp_ff;
   logic [AW-1:0] best_len_ff, best_start_ff, prev_len_ff, next_len_ff;
   logic [AW-1:0] endp_len_ff, endp_start_ff;

   // alignment of the request size
   logic [3:0]    k;
   logic [32:0]   aligned;
   logic [31:0]   sm1;
   assign k = (align_log2 > ALIGN_LOG2_MAX) ? ALIGN_LOG2_MAX : align_log2;
   assign sm1 = req_size - 32'd1;
   assign aligned = ((33'(sm1 >> k)) + 33'd1) << k;

   logic align_ovf;
   always_comb begin
      if (req_size == 32'd0) align_ovf = 1'b0;
      else if (AW >= 33)     align_ovf = 1'b0;
      else                   align_ovf = (XW'(aligned) > XW'({AW{1'b1}}));
   end

   // The table has a registered read port. Entry 0 is read in the check cycle,
   // and during the scan the entry after the one being examined is read.
   logic [AW-1:0] rd_start_ff, rd_len_ff;
   logic [IW-1:0] rd_idx;
   assign rd_idx = !ctl.scan ? idx_ff :
                   ((idx_ff == LAST_IDX) ? '0 : idx_ff + IW'(1));

   logic [AW-1:0] cur_start, cur_len;
   logic [XW-1:0] cur_end;
   logic          cur_v;
   assign cur_start = rd_start_ff;
   assign cur_len   = rd_len_ff;
   assign cur_v     = valid_ff[idx_ff];
   assign cur_end   = XW'(cur_start) + XW'(cur_len);

   logic alloc_q, free_q;
   assign alloc_q = (cmd_ff == CMD_ALLOC);
   assign free_q  = (cmd_ff == CMD_FREE);

   // overflow and over-free checks made in the check cycle
   logic [XW-1:0] amax;
   logic          chk_done;
   logic [1:0]    chk_status;
   logic [AW-1:0] chk_offset;
   assign amax = XW'({AW{1'b1}});
   always_comb begin
      chk_done   = 1'b1;
      chk_status = ST_OK;
      chk_offset = '0;
      if (alloc_q) begin
         if (ovf_ff) chk_status = ST_OVERFLOW;
         else if (need_ff == '0) chk_offset = peak_ff;
         else if (XW'(used_ff) > amax - XW'(need_ff)) chk_status = ST_OVERFLOW;
         else chk_done = 1'b0;
      end else if (free_q) begin
         if (ovf_ff) chk_status = ST_OVERFLOW;
         else if (need_ff == '0) chk_status = ST_OK;
         else if (XW'(addr_ff) > amax - XW'(need_ff)) chk_status = ST_OVERFLOW;
         else if (used_ff < need_ff) chk_status = ST_OVERFREE;
         else chk_done = 1'b0;
      end
   end

   assign sts.early_done = chk_done;
   assign sts.scan_last  = (idx_ff == LAST_IDX);

   // apply decisions
   logic [XW-1:0] grow;
   assign grow = XW'(need_ff) - XW'(endp_len_ff);

   logic          wr_en;
   logic [IW-1:0] wr_idx;
   logic [AW-1:0] wr_start, wr_len;
   logic [AW-1:0] peak_in, used_in;

   always_comb begin
      valid_in  = valid_ff;
      peak_in   = peak_ff;
      used_in   = used_ff;
      status_in = status_ff;
      offset_in = offset_ff;
      wr_en     = 1'b0;
      wr_idx    = '0;
      wr_start  = '0;
      wr_len    = '0;
      if (ctl.clear) begin
         valid_in  = '0;
         peak_in   = '0;
         used_in   = '0;
         status_in = ST_OK;
         offset_in = '0;
      end else if (ctl.check) begin
         status_in = chk_status;
         offset_in = chk_offset;
      end else if (ctl.apply) begin
         status_in = ST_OK;
         offset_in = '0;
         if (alloc_q) begin
            used_in = used_ff + need_ff;
            if (best_hit_ff) begin
               offset_in = best_start_ff;
               if (best_len_ff > need_ff) begin
                  wr_en    = 1'b1;
                  wr_idx   = best_ff;
                  wr_start = best_start_ff + need_ff;
                  wr_len   = best_len_ff - need_ff;
               end else begin
                  valid_in[best_ff] = 1'b0;
               end
            end else if (endp_hit_ff) begin
               if (XW'(peak_ff) > amax - grow) begin
                  status_in = ST_OVERFLOW;
                  used_in   = used_ff;
               end else begin
                  offset_in          = endp_start_ff;
                  peak_in            = peak_ff + AW'(grow);
                  valid_in[endp_ff]  = 1'b0;
               end
            end else if (XW'(peak_ff) > amax - XW'(need_ff)) begin
               status_in = ST_OVERFLOW;
               used_in   = used_ff;
            end else begin
               offset_in = peak_ff;
               peak_in   = peak_ff + need_ff;
            end
         end else begin
            used_in = used_ff - need_ff;
            if (prev_hit_ff) begin
               wr_en  = 1'b1;
               wr_idx = prev_ff;
               wr_start = best_start_ff; // unused for prev update
               if (next_hit_ff && next_ff != prev_ff) begin
                  wr_len = prev_len_ff + need_ff + next_len_ff;
                  valid_in[next_ff] = 1'b0;
               end else begin
                  wr_len = prev_len_ff + need_ff;
               end
            end else if (next_hit_ff) begin
               wr_en    = 1'b1;
               wr_idx   = next_ff;
               wr_start = addr_ff;
               wr_len   = next_len_ff + need_ff;
            end else if (empty_hit_ff) begin
               wr_en    = 1'b1;
               wr_idx   = empty_ff;
               wr_start = addr_ff;
               wr_len   = need_ff;
               valid_in[empty_ff] = 1'b1;
            end else begin
               status_in = ST_FULL;
               used_in   = used_ff;
            end
         end
      end
   end

   // A merge into a lower neighbour keeps its start.
   logic keep_start;
   assign keep_start = free_q && prev_hit_ff;

   always_ff @(posedge clock) begin
      if (ctl.apply && wr_en) begin
         if (!keep_start) start_mem[wr_idx] <= wr_start;
         len_mem[wr_idx] <= wr_len;
      end
      rd_start_ff <= start_mem[rd_idx];
      rd_len_ff   <= len_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         peak_ff   <= '0;
         used_ff   <= '0;
         rsp_valid <= 1'b0;
         idx_ff    <= '0;
      end else begin
         valid_ff  <= valid_in;
         peak_ff   <= peak_in;
         used_ff   <= used_in;
         rsp_valid <= ctl.respond;
         if (ctl.load) idx_ff <= '0;
         else if (ctl.scan) idx_ff <= (idx_ff == LAST_IDX) ? '0 : idx_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      offset_ff <= offset_in;
      if (ctl.load) begin
         cmd_ff  <= req_cmd;
         need_ff <= (req_size == 32'd0) ? '0 : AW'(aligned);
         ovf_ff  <= align_ovf;
         addr_ff <= AW'(req_addr);
         tail_ff <= AW'(req_addr) + AW'(aligned);
         best_hit_ff  <= 1'b0;
         prev_hit_ff  <= 1'b0;
         next_hit_ff  <= 1'b0;
         empty_hit_ff <= 1'b0;
         endp_hit_ff  <= 1'b0;
      end else if (ctl.scan) begin
         if (cur_v && cur_len >= need_ff &&
             (!best_hit_ff || cur_len < best_len_ff ||
              (cur_len == best_len_ff && cur_start < best_start_ff))) begin
            best_hit_ff   <= 1'b1;
            best_ff       <= idx_ff;
            best_len_ff   <= cur_len;
            best_start_ff <= cur_start;
         end
         if (cur_v && !endp_hit_ff && cur_end == XW'(peak_ff)) begin
            endp_hit_ff   <= 1'b1;
            endp_ff       <= idx_ff;
            endp_len_ff   <= cur_len;
            endp_start_ff <= cur_start;
         end
         if (cur_v && !prev_hit_ff && cur_end == XW'(addr_ff)) begin
            prev_hit_ff <= 1'b1;
            prev_ff     <= idx_ff;
            prev_len_ff <= cur_len;
         end
         if (cur_v && !next_hit_ff && cur_start == tail_ff) begin
            next_hit_ff <= 1'b1;
            next_ff     <= idx_ff;
            next_len_ff <= cur_len;
         end
         if (!cur_v && !empty_hit_ff) begin
            empty_hit_ff <= 1'b1;
            empty_ff     <= idx_ff;
         end
      end
   end

   assign rsp_offset       = 32'(offset_ff);
   assign rsp_high_mark    = 32'(peak_ff);
   assign rsp_bytes_in_use = 32'(used_ff);
   assign rsp_status       = status_ff;
endmodule

// File: rtl/best_fit_offset_allocator.sv
// Best-fit offset allocator with coalescing of free neighbours.
// Zero-size, erroneous, clear and unknown requests respond after the check state;
// others first scan the free table one entry per cycle. A new request is not taken
// until the last is answered: busy drops in the cycle that carries the response, so
// the next request can be taken at its end. Reset (synchronous, active high) empties
// the table, zeroes the high mark and the used count, and restores alignment_log2 to 8.
// The receiver cannot stall.
module best_fit_offset_allocator #(
   parameter int FREE_ENTRIES = 64,
   parameter int ADDR_BITS    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_size,
   input  logic [31:0] req_addr,
   output logic        rsp_valid,
   output logic [31:0] rsp_offset,
   output logic [31:0] rsp_high_mark,
   output logic [31:0] rsp_bytes_in_use,
   output logic [1:0]  rsp_status,
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata
);
   import bfoa_pkg::*;

   // The alignment register; the user must write it only while the block is idle, as the block does not enforce this.
   logic [3:0] align_ff;
   always_ff @(posedge clock) begin
      if (reset)       align_ff <= ALIGN_LOG2_RESET;
      else if (csr_we) align_ff <= csr_wdata;
   end

   ctl_type ctl;
   sts_type sts;

   bfoa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .ctl   (ctl),
      .sts   (sts)
   );

   // A clear request takes effect in the check cycle of the sequence.
   ctl_type dp_ctl;
   logic    clr_pend_ff;
   always_ff @(posedge clock) begin
      if (reset) clr_pend_ff <= 1'b0;
      else if (ctl.load) clr_pend_ff <= (req_cmd == CMD_CLEAR);
      else if (ctl.check) clr_pend_ff <= 1'b0;
   end
   always_comb begin
      dp_ctl       = ctl;
      dp_ctl.clear = ctl.check && clr_pend_ff;
   end

   bfoa_datapath #(
      .FREE_ENTRIES (FREE_ENTRIES),
      .ADDR_BITS    (ADDR_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (dp_ctl),
      .sts              (sts),
      .align_log2       (align_ff),
      .req_cmd          (req_cmd),
      .req_size         (req_size),
      .req_addr         (req_addr),
      .rsp_valid        (rsp_valid),
      .rsp_offset       (rsp_offset),
      .rsp_high_mark    (rsp_high_mark),
      .rsp_bytes_in_use (rsp_bytes_in_use),
      .rsp_status       (rsp_status)
   );

   // Responses are never back to back, an idle start is taken, and error responses carry offset zero.
   a_resp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(rsp_valid)) else $error("back-to-back responses");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("request not taken");
   a_error_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_offset == 32'd0))
      else $error("error response with nonzero offset");
endmodule
